// ===== rtl/core/hhfe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HTTP header field extractor package
// Shared constants, types and pattern matchers of the extractor.
// ----------------------------------------------------------------------------
package hhfe_pkg;

   localparam int TEXT_MAX_DEFAULT = 29;

   localparam int BANK_W    = 2;
   localparam int NUM_BANKS = 3;

   localparam int POS_W = 11;
   localparam logic [POS_W-1:0] POS_MAX = 11'd2047;

   localparam int ADDR_FIRST = 26;
   localparam int PORT_FIRST = 34;

   localparam logic [7:0] OFFSET_RESET = 8'd54;

   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_NUL   = 8'h00;

   localparam logic [31:0] PAT_HTTP = "HTTP";
   localparam logic [39:0] PAT_HOST = "Host:";
   localparam logic [2:0]  PAT_HTTP_LEN = 3'd4;
   localparam logic [2:0]  PAT_HOST_LEN = 3'd5;

   typedef enum logic [1:0] {
      KIND_HEADER = 2'd0,
      KIND_HOST   = 2'd1,
      KIND_TOKEN  = 2'd2
   } kind_type;

   typedef struct packed {
      logic [31:0] packet_number;
      logic [31:0] source_address;
      logic [31:0] dest_address;
      logic [15:0] source_port;
      logic [15:0] dest_port;
   } meta_type;

   typedef struct packed {
      logic              start;
      meta_type          meta;
      logic [BANK_W-1:0] host_bank;
      logic [BANK_W-1:0] token_bank;
   } run_type;

   function automatic logic [2:0] match_http(input logic [2:0] prog, input logic [7:0] c);
      logic [2:0] p;
      logic [7:0] want;
      p = (prog >= PAT_HTTP_LEN) ? 3'd0 : prog;
      want = PAT_HTTP[(3 - int'(p)) * 8 +: 8];
      if (c == want) begin
         return p + 3'd1;
      end
      return (c == PAT_HTTP[31:24]) ? 3'd1 : 3'd0;
   endfunction

   function automatic logic [2:0] match_host(input logic [2:0] prog, input logic [7:0] c);
      logic [2:0] p;
      logic [7:0] want;
      p = (prog >= PAT_HOST_LEN) ? 3'd0 : prog;
      want = PAT_HOST[(4 - int'(p)) * 8 +: 8];
      if (c == want) begin
         return p + 3'd1;
      end
      return (c == PAT_HOST[39:32]) ? 3'd1 : 3'd0;
   endfunction

endpackage

// ===== rtl/core/hhfe_text_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text memory
// Byte-wide memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module hhfe_text_mem import hhfe_pkg::*; #(
   parameter int DEPTH  = 96,
   parameter int ADDR_W = 7
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [7:0]        wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]        rd_data
);

   logic [7:0] mem_ff [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/hhfe_scan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame scanner
// Tracks the byte position, latches addresses and ports, runs the line
// parser and writes candidate text into the banked text memories.
// ----------------------------------------------------------------------------
module hhfe_scan import hhfe_pkg::*; #(
   parameter int TEXT_MAX = TEXT_MAX_DEFAULT,
   parameter int LEN_W    = $clog2(TEXT_MAX + 1)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [7:0]              req_frame_byte,
   input  logic                    req_end_of_frame,
   input  logic                    csr_write_enable,
   input  logic [7:0]              csr_write_data,
   input  logic                    drain_busy,
   output logic                    host_wr_en,
   output logic [BANK_W+LEN_W-1:0] host_wr_addr,
   output logic                    token_wr_en,
   output logic [BANK_W+LEN_W-1:0] token_wr_addr,
   output logic [7:0]              wr_data,
   output run_type                 run,
   output logic [LEN_W-1:0]        run_host_len,
   output logic [LEN_W-1:0]        run_token_len
);

   logic              accept;
   logic [7:0]        c;
   logic [2:0]        php_step;
   logic [2:0]        lhost_step;
   logic [2:0]        lhttp_step;

   logic [7:0]        offset_ff, offset_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [31:0]       pkt_ff, pkt_in;
   logic [2:0]        php_ff, php_in;
   logic [2:0]        lhost_ff, lhost_in;
   logic [2:0]        lhttp_ff, lhttp_in;
   logic              colon_ff, colon_in;
   logic              sp1_ff, sp1_in;
   logic              sp2_ff, sp2_in;
   logic              lhas_host_ff, lhas_host_in;
   logic              lhas_http_ff, lhas_http_in;
   logic              prev_empty_ff, prev_empty_in;
   logic              stopped_ff, stopped_in;
   logic              ended_ff, ended_in;
   logic              seen_ff, seen_in;
   logic [63:0]       addr_ff, addr_in;
   logic [31:0]       port_ff, port_in;
   logic [LEN_W-1:0]  chost_ff, chost_in;
   logic [LEN_W-1:0]  ctok_ff, ctok_in;
   logic [LEN_W-1:0]  khost_ff, khost_in;
   logic [LEN_W-1:0]  ktok_ff, ktok_in;
   logic [BANK_W-1:0] hc_ff, hc_in;
   logic [BANK_W-1:0] hk_ff, hk_in;
   logic [BANK_W-1:0] hd_ff, hd_in;
   logic [BANK_W-1:0] tc_ff, tc_in;
   logic [BANK_W-1:0] tk_ff, tk_in;
   logic [BANK_W-1:0] td_ff, td_in;

   // A frame end may not hand over a new run while the last one is still read out.
   assign req_ready = !(drain_busy && req_end_of_frame);
   assign accept    = req_valid && req_ready;
   assign c         = req_frame_byte;
   assign wr_data   = req_frame_byte;

   assign php_step   = match_http(php_ff, c);
   assign lhost_step = match_host(lhost_ff, c);
   assign lhttp_step = match_http(lhttp_ff, c);

   always_comb begin
      offset_in     = csr_write_enable ? csr_write_data : offset_ff;
      pos_in        = pos_ff;
      pkt_in        = pkt_ff;
      php_in        = php_ff;
      lhost_in      = lhost_ff;
      lhttp_in      = lhttp_ff;
      colon_in      = colon_ff;
      sp1_in        = sp1_ff;
      sp2_in        = sp2_ff;
      lhas_host_in  = lhas_host_ff;
      lhas_http_in  = lhas_http_ff;
      prev_empty_in = prev_empty_ff;
      stopped_in    = stopped_ff;
      ended_in      = ended_ff;
      seen_in       = seen_ff;
      addr_in       = addr_ff;
      port_in       = port_ff;
      chost_in      = chost_ff;
      ctok_in       = ctok_ff;
      khost_in      = khost_ff;
      ktok_in       = ktok_ff;
      hc_in         = hc_ff;
      hk_in         = hk_ff;
      hd_in         = hd_ff;
      tc_in         = tc_ff;
      tk_in         = tk_ff;
      td_in         = td_ff;
      host_wr_en    = 1'b0;
      token_wr_en   = 1'b0;
      host_wr_addr  = {hc_ff, chost_ff};
      token_wr_addr = {tc_ff, ctok_ff};
      run           = '0;
      run_host_len  = '0;
      run_token_len = '0;

      if (accept) begin
         for (int k = 0; k < 8; k++) begin
            if (pos_ff == POS_W'(ADDR_FIRST + k)) begin
               addr_in[(7 - k) * 8 +: 8] = c;
            end
         end
         for (int k = 0; k < 4; k++) begin
            if (pos_ff == POS_W'(PORT_FIRST + k)) begin
               port_in[(3 - k) * 8 +: 8] = c;
            end
         end

         if ((pos_ff >= {3'b000, offset_ff}) && !ended_ff) begin
            if (c == CHAR_NUL) begin
               ended_in = 1'b1;
            end else begin
               if (php_step == PAT_HTTP_LEN) begin
                  seen_in = 1'b1;
                  php_in  = 3'd0;
               end else begin
                  php_in = php_step;
               end
               if (!stopped_ff) begin
                  if (c == CHAR_LF) begin
                     // The finished candidate bank becomes the kept one.
                     if (lhas_host_ff) begin
                        hk_in    = hc_ff;
                        hc_in    = hk_ff;
                        khost_in = chost_ff;
                     end else if (lhas_http_ff) begin
                        tk_in   = tc_ff;
                        tc_in   = tk_ff;
                        ktok_in = ctok_ff;
                     end
                     colon_in     = 1'b0;
                     sp1_in       = 1'b0;
                     sp2_in       = 1'b0;
                     lhas_host_in = 1'b0;
                     lhas_http_in = 1'b0;
                     lhost_in     = 3'd0;
                     lhttp_in     = 3'd0;
                     chost_in     = '0;
                     ctok_in      = '0;
                     if (prev_empty_ff) begin
                        stopped_in = 1'b1;
                     end
                     prev_empty_in = 1'b1;
                  end else begin
                     prev_empty_in = 1'b0;
                     if (lhost_step == PAT_HOST_LEN) begin
                        lhas_host_in = 1'b1;
                        lhost_in     = 3'd0;
                     end else begin
                        lhost_in = lhost_step;
                     end
                     if (lhttp_step == PAT_HTTP_LEN) begin
                        lhas_http_in = 1'b1;
                        lhttp_in     = 3'd0;
                     end else begin
                        lhttp_in = lhttp_step;
                     end
                     if (colon_ff) begin
                        if (chost_ff < LEN_W'(TEXT_MAX)) begin
                           host_wr_en = 1'b1;
                           chost_in   = chost_ff + LEN_W'(1);
                        end
                     end else if (c == CHAR_COLON) begin
                        colon_in = 1'b1;
                     end
                     if (!sp1_ff) begin
                        if (c == CHAR_SPACE) begin
                           sp1_in = 1'b1;
                        end
                     end else if (!sp2_ff) begin
                        if (c == CHAR_SPACE) begin
                           sp2_in = 1'b1;
                        end else if (ctok_ff < LEN_W'(TEXT_MAX)) begin
                           token_wr_en = 1'b1;
                           ctok_in     = ctok_ff + LEN_W'(1);
                        end
                     end
                  end
               end
            end
         end

         pos_in = (pos_ff != POS_MAX) ? pos_ff + POS_W'(1) : pos_ff;

         if (req_end_of_frame) begin
            if (seen_in) begin
               pkt_in                   = pkt_ff + 32'd1;
               run.start                = 1'b1;
               run.meta.packet_number   = pkt_ff + 32'd1;
               run.meta.source_address  = addr_in[63:32];
               run.meta.dest_address    = addr_in[31:0];
               run.meta.source_port     = port_in[31:16];
               run.meta.dest_port       = port_in[15:0];
               run.host_bank            = hk_in;
               run.token_bank           = tk_in;
               run_host_len             = khost_in;
               run_token_len            = ktok_in;
               // The kept banks go to the drain side; its free banks come back.
               hk_in = hd_ff;
               hd_in = run.host_bank;
               tk_in = td_ff;
               td_in = run.token_bank;
            end
            pos_in        = '0;
            php_in        = 3'd0;
            lhost_in      = 3'd0;
            lhttp_in      = 3'd0;
            colon_in      = 1'b0;
            sp1_in        = 1'b0;
            sp2_in        = 1'b0;
            lhas_host_in  = 1'b0;
            lhas_http_in  = 1'b0;
            prev_empty_in = 1'b0;
            stopped_in    = 1'b0;
            ended_in      = 1'b0;
            seen_in       = 1'b0;
            addr_in       = '0;
            port_in       = '0;
            chost_in      = '0;
            ctok_in       = '0;
            khost_in      = '0;
            ktok_in       = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff     <= OFFSET_RESET;
         pos_ff        <= '0;
         pkt_ff        <= '0;
         php_ff        <= '0;
         lhost_ff      <= '0;
         lhttp_ff      <= '0;
         colon_ff      <= 1'b0;
         sp1_ff        <= 1'b0;
         sp2_ff        <= 1'b0;
         lhas_host_ff  <= 1'b0;
         lhas_http_ff  <= 1'b0;
         prev_empty_ff <= 1'b0;
         stopped_ff    <= 1'b0;
         ended_ff      <= 1'b0;
         seen_ff       <= 1'b0;
         addr_ff       <= '0;
         port_ff       <= '0;
         chost_ff      <= '0;
         ctok_ff       <= '0;
         khost_ff      <= '0;
         ktok_ff       <= '0;
         hc_ff         <= BANK_W'(0);
         hk_ff         <= BANK_W'(1);
         hd_ff         <= BANK_W'(2);
         tc_ff         <= BANK_W'(0);
         tk_ff         <= BANK_W'(1);
         td_ff         <= BANK_W'(2);
      end else begin
         offset_ff     <= offset_in;
         pos_ff        <= pos_in;
         pkt_ff        <= pkt_in;
         php_ff        <= php_in;
         lhost_ff      <= lhost_in;
         lhttp_ff      <= lhttp_in;
         colon_ff      <= colon_in;
         sp1_ff        <= sp1_in;
         sp2_ff        <= sp2_in;
         lhas_host_ff  <= lhas_host_in;
         lhas_http_ff  <= lhas_http_in;
         prev_empty_ff <= prev_empty_in;
         stopped_ff    <= stopped_in;
         ended_ff      <= ended_in;
         seen_ff       <= seen_in;
         addr_ff       <= addr_in;
         port_ff       <= port_in;
         chost_ff      <= chost_in;
         ctok_ff       <= ctok_in;
         khost_ff      <= khost_in;
         ktok_ff       <= ktok_in;
         hc_ff         <= hc_in;
         hk_ff         <= hk_in;
         hd_ff         <= hd_in;
         tc_ff         <= tc_in;
         tk_ff         <= tk_in;
         td_ff         <= td_in;
      end
   end

endmodule

// ===== rtl/core/hhfe_drain.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result drain
// Walks one run (header, host bytes, token bytes), reads the text banks and
// presents the result words through a registered output stage.
// ----------------------------------------------------------------------------
module hhfe_drain import hhfe_pkg::*; #(
   parameter int TEXT_MAX = TEXT_MAX_DEFAULT,
   parameter int LEN_W    = $clog2(TEXT_MAX + 1)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  run_type                 run,
   input  logic [LEN_W-1:0]        run_host_len,
   input  logic [LEN_W-1:0]        run_token_len,
   output logic                    busy,
   output logic                    rd_en,
   output logic [BANK_W+LEN_W-1:0] host_rd_addr,
   output logic [BANK_W+LEN_W-1:0] token_rd_addr,
   input  logic [7:0]              host_rd_data,
   input  logic [7:0]              token_rd_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [1:0]              rsp_item_kind,
   output logic [7:0]              rsp_text_byte,
   output logic [31:0]             rsp_packet_number,
   output logic [31:0]             rsp_source_address,
   output logic [31:0]             rsp_dest_address,
   output logic [15:0]             rsp_source_port,
   output logic [15:0]             rsp_dest_port,
   output logic                    rsp_last_of_run
);

   typedef enum logic [3:0] {
      DR_IDLE  = 4'b0001,
      DR_HEAD  = 4'b0010,
      DR_HOST  = 4'b0100,
      DR_TOKEN = 4'b1000
   } drain_state_type;

   drain_state_type   state_ff, state_in;
   logic [LEN_W-1:0]  idx_ff, idx_in;
   logic [LEN_W-1:0]  hlen_ff, hlen_in;
   logic [LEN_W-1:0]  tlen_ff, tlen_in;
   logic [BANK_W-1:0] hbank_ff, hbank_in;
   logic [BANK_W-1:0] tbank_ff, tbank_in;
   meta_type          meta_ff, meta_in;

   logic              advance;
   logic              issue;
   kind_type          iss_kind;
   logic              iss_last;
   logic              host_end;
   logic              token_end;

   logic              s1_valid_ff;
   kind_type          s1_kind_ff;
   logic              s1_last_ff;
   meta_type          s1_meta_ff;

   logic              rsp_valid_ff;
   kind_type          rsp_kind_ff;
   logic [7:0]        rsp_text_ff;
   logic              rsp_last_ff;
   meta_type          rsp_meta_ff;

   assign advance       = !rsp_valid_ff || rsp_ready;
   assign busy          = (state_ff != DR_IDLE);
   assign rd_en         = advance;
   assign host_rd_addr  = {hbank_ff, idx_ff};
   assign token_rd_addr = {tbank_ff, idx_ff};
   assign host_end      = (idx_ff == hlen_ff - LEN_W'(1));
   assign token_end     = (idx_ff == tlen_ff - LEN_W'(1));

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      hlen_in  = hlen_ff;
      tlen_in  = tlen_ff;
      hbank_in = hbank_ff;
      tbank_in = tbank_ff;
      meta_in  = meta_ff;
      issue    = 1'b0;
      iss_kind = KIND_HEADER;
      iss_last = 1'b0;
      case (state_ff)
         DR_IDLE: begin
            if (run.start) begin
               state_in = DR_HEAD;
               idx_in   = '0;
               hlen_in  = run_host_len;
               tlen_in  = run_token_len;
               hbank_in = run.host_bank;
               tbank_in = run.token_bank;
               meta_in  = run.meta;
            end
         end
         DR_HEAD: begin
            if (advance) begin
               issue    = 1'b1;
               iss_kind = KIND_HEADER;
               iss_last = (hlen_ff == '0) && (tlen_ff == '0);
               idx_in   = '0;
               if (hlen_ff != '0) begin
                  state_in = DR_HOST;
               end else if (tlen_ff != '0) begin
                  state_in = DR_TOKEN;
               end else begin
                  state_in = DR_IDLE;
               end
            end
         end
         DR_HOST: begin
            if (advance) begin
               issue    = 1'b1;
               iss_kind = KIND_HOST;
               iss_last = host_end && (tlen_ff == '0);
               if (host_end) begin
                  idx_in   = '0;
                  state_in = (tlen_ff != '0) ? DR_TOKEN : DR_IDLE;
               end else begin
                  idx_in = idx_ff + LEN_W'(1);
               end
            end
         end
         DR_TOKEN: begin
            if (advance) begin
               issue    = 1'b1;
               iss_kind = KIND_TOKEN;
               iss_last = token_end;
               if (token_end) begin
                  idx_in   = '0;
                  state_in = DR_IDLE;
               end else begin
                  idx_in = idx_ff + LEN_W'(1);
               end
            end
         end
         default: begin
            state_in = DR_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= DR_IDLE;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (advance) begin
            s1_valid_ff  <= issue;
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      hlen_ff  <= hlen_in;
      tlen_ff  <= tlen_in;
      hbank_ff <= hbank_in;
      tbank_ff <= tbank_in;
      meta_ff  <= meta_in;
      if (advance) begin
         s1_kind_ff  <= iss_kind;
         s1_last_ff  <= iss_last;
         s1_meta_ff  <= meta_ff;
         rsp_kind_ff <= s1_kind_ff;
         rsp_last_ff <= s1_last_ff;
         rsp_meta_ff <= s1_meta_ff;
         case (s1_kind_ff)
            KIND_HOST:  rsp_text_ff <= host_rd_data;
            KIND_TOKEN: rsp_text_ff <= token_rd_data;
            default:    rsp_text_ff <= 8'd0;
         endcase
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_item_kind      = rsp_kind_ff;
   assign rsp_text_byte      = rsp_text_ff;
   assign rsp_packet_number  = rsp_meta_ff.packet_number;
   assign rsp_source_address = rsp_meta_ff.source_address;
   assign rsp_dest_address   = rsp_meta_ff.dest_address;
   assign rsp_source_port    = rsp_meta_ff.source_port;
   assign rsp_dest_port      = rsp_meta_ff.dest_port;
   assign rsp_last_of_run    = rsp_last_ff;

endmodule

// ===== rtl/core/http_header_field_extractor_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HTTP header field extractor
// Scans Ethernet frame bytes, extracts the Host text and the request token
// of HTTP payloads, and emits a header word plus the text bytes per packet.
//
//   Channel   Ports                 Moves
//   req       req_valid/req_ready   one frame byte word per handshake
//   rsp       rsp_valid/rsp_ready   one result word per handshake
//   csr       csr_write_enable      payload offset byte
//
// One frame byte is taken every cycle unless a frame end is held off; each
// qualifying frame end starts a run of 1 + host + token result words read
// from the text memories, issued one per cycle unless the output stalls.
// A frame end is held off while the previous run still has reads to issue.
// Synchronous reset; the text memories need no clearing pass.
// ----------------------------------------------------------------------------
module http_header_field_extractor_unit import hhfe_pkg::*; #(
   parameter int TEXT_MAX = TEXT_MAX_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_frame_byte,
   input  logic        req_end_of_frame,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_item_kind,
   output logic [7:0]  rsp_text_byte,
   output logic [31:0] rsp_packet_number,
   output logic [31:0] rsp_source_address,
   output logic [31:0] rsp_dest_address,
   output logic [15:0] rsp_source_port,
   output logic [15:0] rsp_dest_port,
   output logic        rsp_last_of_run,
   input  logic        csr_write_enable,
   input  logic [7:0]  csr_write_data
);

   localparam int LEN_W  = $clog2(TEXT_MAX + 1);
   localparam int ADDR_W = BANK_W + LEN_W;
   localparam int DEPTH  = NUM_BANKS << LEN_W;

   logic              drain_busy;
   logic              host_wr_en;
   logic              token_wr_en;
   logic [ADDR_W-1:0] host_wr_addr;
   logic [ADDR_W-1:0] token_wr_addr;
   logic [7:0]        wr_data;
   run_type           run;
   logic [LEN_W-1:0]  run_host_len;
   logic [LEN_W-1:0]  run_token_len;
   logic              rd_en;
   logic [ADDR_W-1:0] host_rd_addr;
   logic [ADDR_W-1:0] token_rd_addr;
   logic [7:0]        host_rd_data;
   logic [7:0]        token_rd_data;

   hhfe_scan #(
      .TEXT_MAX (TEXT_MAX),
      .LEN_W    (LEN_W)
   ) u_scan (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_frame_byte   (req_frame_byte),
      .req_end_of_frame (req_end_of_frame),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .drain_busy       (drain_busy),
      .host_wr_en       (host_wr_en),
      .host_wr_addr     (host_wr_addr),
      .token_wr_en      (token_wr_en),
      .token_wr_addr    (token_wr_addr),
      .wr_data          (wr_data),
      .run              (run),
      .run_host_len     (run_host_len),
      .run_token_len    (run_token_len)
   );

   hhfe_text_mem #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_host_mem (
      .clock   (clock),
      .wr_en   (host_wr_en),
      .wr_addr (host_wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (host_rd_addr),
      .rd_data (host_rd_data)
   );

   hhfe_text_mem #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_token_mem (
      .clock   (clock),
      .wr_en   (token_wr_en),
      .wr_addr (token_wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (token_rd_addr),
      .rd_data (token_rd_data)
   );

   hhfe_drain #(
      .TEXT_MAX (TEXT_MAX),
      .LEN_W    (LEN_W)
   ) u_drain (
      .clock              (clock),
      .reset              (reset),
      .run                (run),
      .run_host_len       (run_host_len),
      .run_token_len      (run_token_len),
      .busy               (drain_busy),
      .rd_en              (rd_en),
      .host_rd_addr       (host_rd_addr),
      .token_rd_addr      (token_rd_addr),
      .host_rd_data       (host_rd_data),
      .token_rd_data      (token_rd_data),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_item_kind      (rsp_item_kind),
      .rsp_text_byte      (rsp_text_byte),
      .rsp_packet_number  (rsp_packet_number),
      .rsp_source_address (rsp_source_address),
      .rsp_dest_address   (rsp_dest_address),
      .rsp_source_port    (rsp_source_port),
      .rsp_dest_port      (rsp_dest_port),
      .rsp_last_of_run    (rsp_last_of_run)
   );

endmodule

// ===== rtl/core/hhfe_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Extractor port checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module hhfe_checker import hhfe_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [7:0]  req_frame_byte,
   input logic        req_end_of_frame,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_item_kind,
   input logic [7:0]  rsp_text_byte,
   input logic [31:0] rsp_packet_number,
   input logic [31:0] rsp_source_address,
   input logic [31:0] rsp_dest_address,
   input logic [15:0] rsp_source_port,
   input logic [15:0] rsp_dest_port,
   input logic        rsp_last_of_run,
   input logic        csr_write_enable,
   input logic [7:0]  csr_write_data
);

   a_reset_clears_rsp: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result word valid right after reset");

   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_text_byte)
         && $stable(rsp_item_kind) && $stable(rsp_last_of_run))
      else $error("stalled result word changed");

   a_header_text_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_item_kind == KIND_HEADER) |-> (rsp_text_byte == 8'd0))
      else $error("header word carries a text byte");

   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_of_run |=> rsp_valid)
      else $error("gap inside a result run");

   a_run_same_packet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_of_run
         |=> (rsp_packet_number == $past(rsp_packet_number))
            && (rsp_item_kind != KIND_HEADER))
      else $error("packet changed inside a result run");

endmodule

bind http_header_field_extractor_unit hhfe_checker u_hhfe_checker (.*);
